// ===== src/lslf_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the line fit block.
// No dependencies; every other file refers to it by scoped names.
package lslf_pkg;

   // Point count limit of one set; the count register is sized from it.
   localparam int MAX_POINTS = 1024;

   localparam int X_W      = 16;
   localparam int CNT_W    = $clog2(MAX_POINTS + 1);
   localparam int SUM1_W   = 32;
   localparam int SUM2_W   = 48;
   localparam int B_W      = SUM1_W + 1;
   localparam int ACC_W    = 88;
   localparam int DEN_W    = 64;
   localparam int RES_W    = 32;
   localparam int DCNT_W   = $clog2(ACC_W + 1);
   localparam int STATUS_W = 2;

   localparam int SLOPE_SHIFT = 16;
   localparam int ICPT_SHIFT  = 8;

   localparam logic [STATUS_W-1:0] STATUS_OK       = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_SINGULAR = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = STATUS_W'(2);

   // Operand pairs of the serial multiplier: multiplicand first, multiplier second.
   localparam int PAIR_W = 3;
   localparam logic [PAIR_W-1:0] PAIR_SXX_N  = PAIR_W'(0);
   localparam logic [PAIR_W-1:0] PAIR_SX_SX  = PAIR_W'(1);
   localparam logic [PAIR_W-1:0] PAIR_SXY_N  = PAIR_W'(2);
   localparam logic [PAIR_W-1:0] PAIR_SY_SX  = PAIR_W'(3);
   localparam logic [PAIR_W-1:0] PAIR_SXX_SY = PAIR_W'(4);
   localparam logic [PAIR_W-1:0] PAIR_SXY_SX = PAIR_W'(5);

   typedef struct packed {
      logic                accum;
      logic                clear_sums;
      logic                acc_clear;
      logic                mul_load;
      logic [PAIR_W-1:0]   pair;
      logic                mul_step;
      logic                den_save;
      logic                div_load;
      logic                div_shift8;
      logic                div_step;
      logic                div_round;
      logic                save_slope;
      logic                save_icpt;
      logic                out_load;
      logic [STATUS_W-1:0] out_status;
   } lslf_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic den_zero;
      logic overflow;
   } lslf_stat_type;

endpackage

// ===== src/lslf_ctrl.sv =====
// Sequencer of the line fit: accumulation phase, determinant products, divisions, result.
// Depends on lslf_pkg for codes and the command/status structs.
module lslf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_point,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  lslf_pkg::lslf_stat_type stat,
   output lslf_pkg::lslf_cmd_type  cmd
);

   localparam logic [3:0] ST_ACCUM = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_D1    = 4'd2;
   localparam logic [3:0] ST_D2    = 4'd3;
   localparam logic [3:0] ST_DCHK  = 4'd4;
   localparam logic [3:0] ST_K1    = 4'd5;
   localparam logic [3:0] ST_K2    = 4'd6;
   localparam logic [3:0] ST_KDIV  = 4'd7;
   localparam logic [3:0] ST_KRND  = 4'd8;
   localparam logic [3:0] ST_KSAT  = 4'd9;
   localparam logic [3:0] ST_B1    = 4'd10;
   localparam logic [3:0] ST_B2    = 4'd11;
   localparam logic [3:0] ST_BDIV  = 4'd12;
   localparam logic [3:0] ST_BRND  = 4'd13;
   localparam logic [3:0] ST_BSAT  = 4'd14;
   localparam logic [3:0] ST_OUT   = 4'd15;

   logic [3:0]                    state_ff, state_in;
   logic [lslf_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      status_in = status_ff;
      req_ready = (state_ff == ST_ACCUM);
      unique case (state_ff)
         ST_ACCUM: begin
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_last_point) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.overflow) begin
               status_in = lslf_pkg::STATUS_OVERFLOW;
               state_in  = ST_OUT;
            end else begin
               cmd.acc_clear = 1'b1;
               cmd.mul_load  = 1'b1;
               cmd.pair      = lslf_pkg::PAIR_SXX_N;
               state_in      = ST_D1;
            end
         end
         ST_D1: begin
            if (stat.mul_done) begin
               cmd.mul_load = 1'b1;
               cmd.pair     = lslf_pkg::PAIR_SX_SX;
               state_in     = ST_D2;
            end else cmd.mul_step = 1'b1;
         end
         ST_D2: begin
            if (stat.mul_done) begin
               cmd.den_save = 1'b1;
               state_in     = ST_DCHK;
            end else cmd.mul_step = 1'b1;
         end
         ST_DCHK: begin
            if (stat.den_zero) begin
               status_in = lslf_pkg::STATUS_SINGULAR;
               state_in  = ST_OUT;
            end else begin
               cmd.acc_clear = 1'b1;
               cmd.mul_load  = 1'b1;
               cmd.pair      = lslf_pkg::PAIR_SXY_N;
               state_in      = ST_K1;
            end
         end
         ST_K1: begin
            if (stat.mul_done) begin
               cmd.mul_load = 1'b1;
               cmd.pair     = lslf_pkg::PAIR_SY_SX;
               state_in     = ST_K2;
            end else cmd.mul_step = 1'b1;
         end
         ST_K2: begin
            if (stat.mul_done) begin
               cmd.div_load   = 1'b1;
               cmd.div_shift8 = 1'b0;
               state_in       = ST_KDIV;
            end else cmd.mul_step = 1'b1;
         end
         ST_KDIV: begin
            if (stat.div_done) state_in = ST_KRND;
            else cmd.div_step = 1'b1;
         end
         ST_KRND: begin
            cmd.div_round = 1'b1;
            state_in      = ST_KSAT;
         end
         ST_KSAT: begin
            cmd.save_slope = 1'b1;
            cmd.acc_clear  = 1'b1;
            cmd.mul_load   = 1'b1;
            cmd.pair       = lslf_pkg::PAIR_SXX_SY;
            state_in       = ST_B1;
         end
         ST_B1: begin
            if (stat.mul_done) begin
               cmd.mul_load = 1'b1;
               cmd.pair     = lslf_pkg::PAIR_SXY_SX;
               state_in     = ST_B2;
            end else cmd.mul_step = 1'b1;
         end
         ST_B2: begin
            if (stat.mul_done) begin
               cmd.div_load   = 1'b1;
               cmd.div_shift8 = 1'b1;
               state_in       = ST_BDIV;
            end else cmd.mul_step = 1'b1;
         end
         ST_BDIV: begin
            if (stat.div_done) state_in = ST_BRND;
            else cmd.div_step = 1'b1;
         end
         ST_BRND: begin
            cmd.div_round = 1'b1;
            state_in      = ST_BSAT;
         end
         ST_BSAT: begin
            cmd.save_icpt = 1'b1;
            status_in     = lslf_pkg::STATUS_OK;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = status_ff;
               cmd.clear_sums = 1'b1;
               state_in       = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready)        rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         status_ff    <= lslf_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/lslf_datapath.sv =====
// Datapath of the line fit: point accumulators, shift-add multiplier, restoring divider,
// rounding and saturation, and the result register. Depends on lslf_pkg.
module lslf_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  lslf_pkg::lslf_cmd_type              cmd,
   output lslf_pkg::lslf_stat_type             stat,
   input  logic signed [lslf_pkg::X_W-1:0]     x_value,
   input  logic signed [lslf_pkg::X_W-1:0]     y_value,
   output logic signed [lslf_pkg::RES_W-1:0]   slope,
   output logic signed [lslf_pkg::RES_W-1:0]   intercept,
   output logic        [lslf_pkg::STATUS_W-1:0] status
);

   localparam int ACC_W = lslf_pkg::ACC_W;
   localparam int DEN_W = lslf_pkg::DEN_W;
   localparam int RES_W = lslf_pkg::RES_W;
   localparam logic [ACC_W-1:0] LIM_POS = ACC_W'({1'b0, {(RES_W-1){1'b1}}});
   localparam logic [ACC_W-1:0] LIM_NEG = ACC_W'({1'b1, {(RES_W-1){1'b0}}});

   // accumulators
   logic        [lslf_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                               overflow_ff, overflow_in;
   logic signed [lslf_pkg::SUM1_W-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [lslf_pkg::SUM2_W-1:0] sum_xx_ff, sum_xx_in, sum_xy_ff, sum_xy_in;
   logic signed [2*lslf_pkg::X_W-1:0]  xx, xy;

   // multiplier and divider
   logic signed [ACC_W-1:0]            acc_ff, acc_in, mcand_ff, mcand_in;
   logic        [lslf_pkg::SUM1_W-1:0] mplier_ff, mplier_in;
   logic signed [ACC_W-1:0]            op_a, a_eff;
   logic signed [lslf_pkg::B_W-1:0]    op_b, b_abs;
   logic                               op_sub;
   logic        [DEN_W-1:0]            den_ff, den_in;
   logic        [ACC_W-1:0]            quo_ff, quo_in, acc_u, acc_mag;
   logic        [DEN_W-1:0]            rem_ff, rem_in;
   logic                               neg_ff, neg_in;
   logic        [lslf_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic        [DEN_W:0]              rem_shift, den_ext;
   logic                               rem_ge;
   logic        [ACC_W-1:0]            limit;
   logic        [RES_W-1:0]            mq, sat_val;

   // results
   logic [RES_W-1:0]              slope_res_ff, slope_res_in, icpt_res_ff, icpt_res_in;
   logic [RES_W-1:0]              rsp_slope_ff, rsp_slope_in, rsp_icpt_ff, rsp_icpt_in;
   logic [lslf_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   assign xx = x_value * x_value;
   assign xy = x_value * y_value;

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      sum_x_in    = sum_x_ff;
      sum_y_in    = sum_y_ff;
      sum_xx_in   = sum_xx_ff;
      sum_xy_in   = sum_xy_ff;
      priority if (cmd.clear_sums) begin
         count_in    = '0;
         overflow_in = 1'b0;
         sum_x_in    = '0;
         sum_y_in    = '0;
         sum_xx_in   = '0;
         sum_xy_in   = '0;
      end else if (cmd.accum) begin
         if (count_ff < lslf_pkg::CNT_W'(lslf_pkg::MAX_POINTS)) begin
            count_in  = count_ff + lslf_pkg::CNT_W'(1);
            sum_x_in  = sum_x_ff + lslf_pkg::SUM1_W'(x_value);
            sum_y_in  = sum_y_ff + lslf_pkg::SUM1_W'(y_value);
            sum_xx_in = sum_xx_ff + lslf_pkg::SUM2_W'(xx);
            sum_xy_in = sum_xy_ff + lslf_pkg::SUM2_W'(xy);
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   // operand selection; the second product of each determinant subtracts
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_sub = 1'b0;
      unique case (cmd.pair)
         lslf_pkg::PAIR_SXX_N: begin
            op_a = ACC_W'(sum_xx_ff);
            op_b = $signed({{(lslf_pkg::B_W-lslf_pkg::CNT_W){1'b0}}, count_ff});
         end
         lslf_pkg::PAIR_SX_SX: begin
            op_a   = ACC_W'(sum_x_ff);
            op_b   = lslf_pkg::B_W'(sum_x_ff);
            op_sub = 1'b1;
         end
         lslf_pkg::PAIR_SXY_N: begin
            op_a = ACC_W'(sum_xy_ff);
            op_b = $signed({{(lslf_pkg::B_W-lslf_pkg::CNT_W){1'b0}}, count_ff});
         end
         lslf_pkg::PAIR_SY_SX: begin
            op_a   = ACC_W'(sum_y_ff);
            op_b   = lslf_pkg::B_W'(sum_x_ff);
            op_sub = 1'b1;
         end
         lslf_pkg::PAIR_SXX_SY: begin
            op_a = ACC_W'(sum_xx_ff);
            op_b = lslf_pkg::B_W'(sum_y_ff);
         end
         lslf_pkg::PAIR_SXY_SX: begin
            op_a   = ACC_W'(sum_xy_ff);
            op_b   = lslf_pkg::B_W'(sum_x_ff);
            op_sub = 1'b1;
         end
         default: begin
            op_a   = '0;
            op_b   = '0;
            op_sub = 1'b0;
         end
      endcase
      b_abs = op_b[lslf_pkg::B_W-1] ? -op_b : op_b;
      a_eff = (op_sub ^ op_b[lslf_pkg::B_W-1]) ? -op_a : op_a;
   end

   // divider helpers
   always_comb begin
      acc_u     = acc_ff;
      acc_mag   = acc_ff[ACC_W-1] ? ('0 - acc_u) : acc_u;
      den_ext   = {1'b0, den_ff};
      rem_shift = {rem_ff, quo_ff[ACC_W-1]};
      rem_ge    = (rem_shift >= den_ext);
      limit     = neg_ff ? LIM_NEG : LIM_POS;
      mq        = (quo_ff > limit) ? limit[RES_W-1:0] : quo_ff[RES_W-1:0];
      sat_val   = neg_ff ? ('0 - mq) : mq;
   end

   always_comb begin
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      dcnt_in      = dcnt_ff;
      slope_res_in = slope_res_ff;
      icpt_res_in  = icpt_res_ff;

      if (cmd.acc_clear) acc_in = '0;
      if (cmd.mul_load) begin
         mcand_in  = a_eff;
         mplier_in = b_abs[lslf_pkg::SUM1_W-1:0];
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
      end

      if (cmd.den_save) den_in = acc_ff[DEN_W-1:0];

      priority if (cmd.div_load) begin
         neg_in  = acc_ff[ACC_W-1];
         quo_in  = cmd.div_shift8 ? (acc_mag << lslf_pkg::ICPT_SHIFT)
                                  : (acc_mag << lslf_pkg::SLOPE_SHIFT);
         rem_in  = '0;
         dcnt_in = lslf_pkg::DCNT_W'(ACC_W);
      end else if (cmd.div_step) begin
         rem_in  = rem_ge ? DEN_W'(rem_shift - den_ext) : rem_shift[DEN_W-1:0];
         quo_in  = {quo_ff[ACC_W-2:0], rem_ge};
         dcnt_in = dcnt_ff - lslf_pkg::DCNT_W'(1);
      end else if (cmd.div_round) begin
         // round half away from zero on the magnitude
         if ({rem_ff, 1'b0} >= den_ext) quo_in = quo_ff + ACC_W'(1);
      end

      if (cmd.save_slope) slope_res_in = sat_val;
      if (cmd.save_icpt)  icpt_res_in  = sat_val;
   end

   always_comb begin
      rsp_slope_in  = rsp_slope_ff;
      rsp_icpt_in   = rsp_icpt_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.out_load) begin
         rsp_status_in = cmd.out_status;
         rsp_slope_in  = (cmd.out_status == lslf_pkg::STATUS_OK) ? slope_res_ff : '0;
         rsp_icpt_in   = (cmd.out_status == lslf_pkg::STATUS_OK) ? icpt_res_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         sum_xx_ff   <= '0;
         sum_xy_ff   <= '0;
         mplier_ff   <= '0;
         dcnt_ff     <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         sum_x_ff    <= sum_x_in;
         sum_y_ff    <= sum_y_in;
         sum_xx_ff   <= sum_xx_in;
         sum_xy_ff   <= sum_xy_in;
         mplier_ff   <= mplier_in;
         dcnt_ff     <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      den_ff        <= den_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      slope_res_ff  <= slope_res_in;
      icpt_res_ff   <= icpt_res_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_icpt_ff   <= rsp_icpt_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign stat.mul_done = (mplier_ff == '0);
   assign stat.div_done = (dcnt_ff == '0);
   assign stat.den_zero = (den_ff == '0);
   assign stat.overflow = overflow_ff;

   assign slope     = rsp_slope_ff;
   assign intercept = rsp_icpt_ff;
   assign status    = rsp_status_ff;

endmodule

// ===== src/least_squares_line_fit.sv =====
// Least-squares line fit: one point per cycle is summed; the last point starts the fit.
// The fit runs on the shift-add multiplier (six products, two per determinant) and the
// restoring divider (88 steps plus done, round and saturate, run twice); a singular set
// stops after the D determinant, and a set over MAX_POINTS goes straight to the result.
// Throughput: one point beat per cycle while summing, none during the fit.
// Reset: synchronous, clears sums, sequencer and output valid.
module least_squares_line_fit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [lslf_pkg::X_W-1:0]      req_x_value,
   input  logic signed [lslf_pkg::X_W-1:0]      req_y_value,
   input  logic                                req_last_point,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lslf_pkg::RES_W-1:0]    rsp_slope,
   output logic signed [lslf_pkg::RES_W-1:0]    rsp_intercept,
   output logic        [lslf_pkg::STATUS_W-1:0] rsp_status
);

   // Command and status between sequencer and datapath.
   lslf_pkg::lslf_cmd_type  cmd;
   lslf_pkg::lslf_stat_type stat;

   // Sequencer: takes point beats, then walks D, K and B products and both divisions,
   // and parks the result in the output register once it is free.
   lslf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   // Datapath: sums, serial multiply-accumulate, divider, saturation, result register.
   lslf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .x_value   (req_x_value),
      .y_value   (req_y_value),
      .slope     (rsp_slope),
      .intercept (rsp_intercept),
      .status    (rsp_status)
   );

   // Never overwrite a result beat that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result register loaded while a beat is pending");

   // A taken result beat with no new load drops valid.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !cmd.out_load) |=> !rsp_valid)
      else $error("result beat repeated");

   // The last point of a set stops intake for the fit.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_point) |=> !req_ready)
      else $error("point taken during fit");

   // Error results carry zero slope and intercept.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != lslf_pkg::STATUS_OK)
         |-> (rsp_slope == 0 && rsp_intercept == 0))
      else $error("nonzero fit on error status");

endmodule
